@@ rtl/rltd_pkg.sv @@
// ----------------------------------------------------------------------------
// rltd_pkg: shared types and constants for the run-length text decoder
// Status codes, frame state and result records used by all decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rltd_pkg;

  // Character codes and limits
  localparam logic [7:0]  DIGIT_ONE   = 8'h31;  // '1'
  localparam logic [7:0]  DIGIT_NINE  = 8'h39;  // '9'
  localparam logic [6:0]  MIN_RUN     = 7'd3;
  localparam logic [15:0] LIMIT_RESET = 16'd100;
  localparam logic [15:0] TOTAL_MAX   = 16'hFFFF;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MANY_DIG  = 3'd1,
    ST_SHORT_RUN = 3'd2,
    ST_TRAIL_DIG = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  // Per-frame decoder state
  typedef struct packed {
    logic [1:0]  digit_count;
    logic [6:0]  pending;
    status_e     err;
    logic [15:0] total;
  } frame_t;

  // One result record
  typedef struct packed {
    logic [7:0]  symbol;
    logic [6:0]  run_length;
    status_e     status;
    logic [15:0] total;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/rltd_step.sv @@
// ----------------------------------------------------------------------------
// rltd_step: one-byte decode step
// Combinational next frame state and result for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rltd_step (
  input  rltd_pkg::frame_t  frame_i,
  input  logic [7:0]        symbol_i,
  input  logic              last_i,
  input  logic [15:0]       limit_i,
  output rltd_pkg::frame_t  frame_o,
  output logic              res_vld_o,
  output rltd_pkg::result_t res_o
);
  import rltd_pkg::*;

  logic        is_digit;
  logic [3:0]  digit_val;
  logic [6:0]  run;
  logic [16:0] sum;
  logic        emit;
  frame_t      nxt;

  assign digit_val = symbol_i[3:0];

  always_comb begin
    is_digit = symbol_i inside {[DIGIT_ONE:DIGIT_NINE]};
    nxt      = frame_i;
    emit     = 1'b0;
    run      = (frame_i.digit_count == 2'd0) ? 7'd1 : frame_i.pending;
    sum      = {1'b0, frame_i.total} + {10'd0, run};

    if (frame_i.err == ST_OK) begin
      if (is_digit) begin
        // accumulate count digits
        if (last_i) begin
          nxt.err = ST_TRAIL_DIG;
        end else if (frame_i.digit_count >= 2'd2) begin
          nxt.err = ST_MANY_DIG;
        end else begin
          nxt.pending = (frame_i.digit_count == 2'd0) ? {3'd0, digit_val} :
                        7'((frame_i.pending << 3) + (frame_i.pending << 1)
                           + {3'd0, digit_val});
          nxt.digit_count = frame_i.digit_count + 2'd1;
        end
      end else begin
        // literal byte closes the run
        if (frame_i.digit_count != 2'd0 && run < MIN_RUN) begin
          nxt.err = ST_SHORT_RUN;
        end else begin
          nxt.total = sum[16] ? TOTAL_MAX : sum[15:0];
          if (nxt.total > limit_i) begin
            nxt.err = ST_TOO_LONG;
          end else begin
            emit = 1'b1;
          end
        end
        nxt.digit_count = 2'd0;
        nxt.pending     = 7'd0;
      end
    end

    // result record: run result or pure status on the last byte
    res_o.symbol     = emit ? symbol_i : 8'd0;
    res_o.run_length = emit ? run : 7'd0;
    res_o.status     = nxt.err;
    res_o.total      = nxt.total;
    res_o.last       = last_i;
    res_vld_o        = emit || last_i;

    // end of frame clears the state
    frame_o = nxt;
    if (last_i) begin
      frame_o = '{digit_count: 2'd0, pending: 7'd0, err: ST_OK, total: 16'd0};
    end
  end

endmodule

`default_nettype wire

@@ rtl/rltd_out_reg.sv @@
// ----------------------------------------------------------------------------
// rltd_out_reg: result output register
// Holds one result transaction until downstream takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rltd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rltd_pkg::result_t res_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              stall_i,
  output rltd_pkg::result_t res_o
);
  import rltd_pkg::*;

  logic    vld_q;
  result_t res_q;

  // slot is free when empty or being drained
  assign ready_o = !vld_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ rtl/run_length_text_decoder_core.sv @@
// ----------------------------------------------------------------------------
// run_length_text_decoder_core: run-length text decoder top level
// Decodes digit counts and literal bytes into run results with frame status.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o    | symbol_i, last_i
//   out     | output    | out_valid_o / out_stall_i  | symbol_res_o, run_length_o,
//           |           |                            | status_o, total_o, last_res_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_data_i (output limit)
//
// One byte per cycle sustained while the out channel does not stall; a result
// moves from the input register into the result register that drives the out channel.
// The decode step reads and updates the frame state in the same cycle.
// Reset clears the frame state and sets the output limit to 100.
// A stalled result register holds the byte in the input register and
// raises in_stall_o in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_text_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  symbol_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  symbol_res_o,
  output logic [6:0]  run_length_o,
  output logic [2:0]  status_o,
  output logic [15:0] total_o,
  output logic        last_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import rltd_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_sym_q;
  logic        in_last_q;
  logic [15:0] limit_q;
  frame_t      frame_q;
  frame_t      frame_d;
  logic        step_vld;
  result_t     step_res;
  result_t     out_res;
  logic        out_rdy;
  logic        fire;

  // step fires when a byte is held and the result slot can take it
  assign fire       = in_vld_q && out_rdy;
  assign in_stall_o = in_vld_q && !out_rdy;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_sym_q  <= symbol_i;
      in_last_q <= last_i;
    end
  end

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '{digit_count: 2'd0, pending: 7'd0, err: ST_OK, total: 16'd0};
    end else if (fire) begin
      frame_q <= frame_d;
    end
  end

  rltd_step u_step (
    .frame_i   (frame_q),
    .symbol_i  (in_sym_q),
    .last_i    (in_last_q),
    .limit_i   (limit_q),
    .frame_o   (frame_d),
    .res_vld_o (step_vld),
    .res_o     (step_res)
  );

  rltd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && step_vld),
    .res_i   (step_res),
    .ready_o (out_rdy),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign symbol_res_o = out_res.symbol;
  assign run_length_o = out_res.run_length;
  assign status_o     = out_res.status;
  assign total_o      = out_res.total;
  assign last_res_o   = out_res.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a count never holds more than two digits
  a_digit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q.digit_count != 2'd3)
    else $error("digit count overflow");

  // the last byte of a frame leaves the state cleared
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> frame_q.err == ST_OK && frame_q.total == 16'd0 &&
                          frame_q.digit_count == 2'd0)
    else $error("frame state not cleared after last byte");

  // an error status is only reported on the last result of a frame
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_res_o)
    else $error("error status on a non-final result");

  // the first error of a frame sticks until the frame ends
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q.err != ST_OK && !(fire && in_last_q) |=> $stable(frame_q.err))
    else $error("frame error changed before end of frame");

endmodule

`default_nettype wire
